@@ rtl/ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and constants for the ordered value list: operation and
// status codes, controller states, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;        // capture a new request
    logic    append;      // write value at tail, bump count
    logic    pos_read;    // issue memory read at request position
    logic    take_read;   // latch memory read data as result data
    logic    scan_init;   // restart index pipeline at head
    logic    shift_init;  // restart index pipeline just past the match
    logic    step;        // advance index pipeline by one entry
    logic    shift_wr;    // write previous read back one slot lower
    logic    dec;         // drop count by one
    logic    set_status;  // load status register
    status_t status_code;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic pos_ok;
    logic hit;
    logic exhausted;
  } dp_stat_t;

endpackage

@@ rtl/ovl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ovl_ctrl
// Request sequencer: dispatches each operation, runs the scan and the
// gap-closing shift, and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module ovl_ctrl
  import ovl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output cmd_t     cmd,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_APPEND: state_next = S_RESP;
          OP_READ:   state_next = stat.pos_ok ? S_READ : S_RESP;
          default:   state_next = S_SCAN;
        endcase
      end
      S_READ: state_next = S_RESP;
      S_SCAN: begin
        priority if (stat.hit) begin
          state_next = (stat.op == OP_REMOVE) ? S_SHIFT : S_RESP;
        end else if (stat.exhausted) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat.exhausted) state_next = S_RESP;
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.status_code = ST_OK;
    busy            = (state != S_IDLE);
    done            = 1'b0;
    unique case (state)
      S_IDLE: cmd.load = start;
      S_EXEC: begin
        unique case (stat.op)
          OP_APPEND: begin
            cmd.set_status = 1'b1;
            if (stat.full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          OP_READ: begin
            if (stat.pos_ok) begin
              cmd.pos_read = 1'b1;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end
          end
          default: cmd.scan_init = 1'b1;
        endcase
      end
      S_READ: begin
        cmd.take_read  = 1'b1;
        cmd.set_status = 1'b1;
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          if (stat.op == OP_REMOVE) begin
            cmd.shift_init = 1'b1;
          end else begin
            cmd.set_status = 1'b1;
          end
        end else if (stat.exhausted) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.exhausted) begin
          cmd.dec        = 1'b1;
          cmd.set_status = 1'b1;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      S_RESP: done = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/ovl_dp.sv @@
// ----------------------------------------------------------------------------
// ovl_dp
// Datapath: entry memory with one write and one registered read port,
// request registers, entry count, and the index pipeline used for scanning
// and for closing the gap after a removal.
// ----------------------------------------------------------------------------
module ovl_dp
  import ovl_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [OP_W-1:0]     op,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic [POS_W-1:0]    position,
  output dp_stat_t            stat,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  read_data,
  output logic [COUNT_W-1:0]  count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata;

  op_t                   op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [POS_W-1:0]      pos_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         idx;
  logic [IW-1:0]         cmp_idx;
  logic                  cmp_vld;
  status_t               status_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic                  more;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  we;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [63:0]           data_wide;

  assign more    = (idx < count_q);
  assign rd_en   = cmd.pos_read || (cmd.step && more);
  assign rd_addr = cmd.pos_read ? IW'(pos_q) : idx[IW-1:0];
  assign we      = cmd.append || (cmd.shift_wr && cmp_vld);
  assign wr_addr = cmd.append ? count_q[IW-1:0] : (cmp_idx - IW'(1));
  assign wr_data = cmd.append ? val_q : rdata;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
      idx     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      if (cmd.append) begin
        count_q <= count_q + CW'(1);
      end else if (cmd.dec) begin
        count_q <= count_q - CW'(1);
      end

      if (cmd.scan_init) begin
        idx     <= '0;
        cmp_vld <= 1'b0;
      end else if (cmd.shift_init) begin
        // resume reading one past the matched entry
        idx     <= CW'(cmp_idx) + CW'(1);
        cmp_vld <= 1'b0;
      end else if (cmd.step) begin
        cmp_vld <= more;
        if (more) idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && more) cmp_idx <= idx[IW-1:0];
    if (cmd.load) begin
      op_q   <= op_t'(op);
      val_q  <= DATA_WIDTH'(item_value);
      pos_q  <= position;
      data_q <= '0;
    end else if (cmd.take_read) begin
      data_q <= rdata;
    end
    if (cmd.set_status) status_q <= cmd.status_code;
  end

  assign stat.op        = op_q;
  assign stat.full      = (count_q == CW'(CAPACITY));
  assign stat.pos_ok    = (PW'(pos_q) < PW'(count_q));
  assign stat.hit       = cmp_vld && (rdata == val_q);
  assign stat.exhausted = !more && !cmp_vld;

  assign data_wide = 64'(data_q);
  assign status    = status_q;
  assign read_data = data_wide[VALUE_W-1:0];
  assign count     = COUNT_W'(count_q);

endmodule

@@ rtl/ordered_value_list.sv @@
// An append passes from start through S_EXEC to S_RESP; a read with a valid
// position adds S_READ; search and remove scan in S_SCAN, remove then S_SHIFT.
// One request at a time; busy stays high through the done cycle, so a new
// start is taken at the earliest in the cycle after done. The single read port
// of the entry memory sets the scan and shift at one entry per cycle.
// Reset empties the list; done is a one-cycle strobe that cannot be stalled.
// ----------------------------------------------------------------------------
// ordered_value_list
// Bounded ordered list of values with append, remove, search and indexed
// read; every request returns one result with status and entry count.
// ----------------------------------------------------------------------------
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic [POS_W-1:0]    position,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  read_data,
  output logic [COUNT_W-1:0]  count
);

  cmd_t     cmd;
  dp_stat_t stat;

  ovl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ovl_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .item_value (item_value),
    .position   (position),
    .stat       (stat),
    .status     (status),
    .read_data  (read_data),
    .count      (count)
  );

endmodule

@@ rtl/ovl_chk.sv @@
// ----------------------------------------------------------------------------
// ovl_chk
// Port-level checks on the ordered value list, bound to the top level.
// ----------------------------------------------------------------------------
module ovl_chk
  import ovl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [VALUE_W-1:0]  read_data,
  input logic [COUNT_W-1:0]  count
);

  // an accepted transfer keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepted request");

  // result strobe falls inside a busy window and never repeats back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !done))
    else $error("result strobe repeated or outside busy");

  // read data is zero on every failed request
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (read_data == '0))
    else $error("read data nonzero on failed request");

  // full refusal only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind ordered_value_list ovl_chk #(.CAPACITY(CAPACITY)) u_ovl_chk (.*);

@@ tb/sv/ordered_value_list_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_value_list_tb
// Self-checking bench for the ordered value list. A directed table walks the
// empty, single-entry and full corners, then random requests drawn from a
// small value pool keep search and remove hitting. Each result is checked
// against the table or a local list predictor; requests idle at random.
// ----------------------------------------------------------------------------
module ordered_value_list_tb;
  import ovl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 16;
  localparam int POOL_SIZE  = 8;
  localparam int RAND_ITEMS = 100;
  localparam int DRAIN_CYC  = 2 * CAPACITY + 16;

  typedef struct packed {
    status_t             st;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  cnt;
  } result_t;

  typedef struct packed {
    op_t                 op;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    pos;
    logic [4:0]          rpt;
    logic                typed;
    status_t             st;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  cnt;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     op = '0;
  logic [VALUE_W-1:0]  item_value = '0;
  logic [POS_W-1:0]    position = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_data;
  logic [COUNT_W-1:0]  count;

  // Shadow of the list contents
  logic [VALUE_W-1:0]  list_entries [CAPACITY];
  int                  list_len = 0;

  result_t             pending_results[$];
  stim_row_t           directed_rows[$];
  logic [VALUE_W-1:0]  value_pool [POOL_SIZE];
  result_t             oldest_result;

  int mismatches    = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int full_refusals = 0;
  int list_emptied  = 0;
  int search_hits   = 0;

  ordered_value_list i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .item_value (item_value),
    .position   (position),
    .done       (done),
    .status     (status),
    .read_data  (read_data),
    .count      (count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Apply one request to the shadow list and return its result
  task automatic predict_list_op(input op_t o, input logic [VALUE_W-1:0] v,
                                 input logic [POS_W-1:0] p, output result_t r);
    int hit_idx;
    hit_idx = list_len;
    r.st = ST_OK;
    r.data = '0;
    if (o == OP_REMOVE || o == OP_SEARCH) begin
      for (int i = list_len - 1; i >= 0; i--) begin
        if (list_entries[i] == v) hit_idx = i;
      end
    end
    case (o)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.st = ST_FULL;
          full_refusals++;
        end else begin
          list_entries[list_len] = v;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (hit_idx >= list_len) begin
          r.st = ST_NOT_FOUND;
        end else begin
          // close the gap, keeping order
          for (int i = hit_idx; i + 1 < list_len; i++) list_entries[i] = list_entries[i + 1];
          list_len--;
          if (list_len == 0) list_emptied++;
        end
      end
      OP_SEARCH: begin
        if (hit_idx >= list_len) r.st = ST_NOT_FOUND;
        else search_hits++;
      end
      default: begin
        if (int'(p) >= list_len) r.st = ST_RANGE;
        else r.data = list_entries[p];
      end
    endcase
    r.cnt = list_len[COUNT_W-1:0];
  endtask

  // Hold the request until it transfers, then record what it must return
  task automatic send_request(input op_t o, input logic [VALUE_W-1:0] v,
                              input logic [POS_W-1:0] p, input logic typed,
                              input result_t typed_r, input int idle_pct);
    result_t model_r;
    op <= o;
    item_value <= v;
    position <= p;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_list_op(o, v, p, model_r);
    pending_results.insert(pending_results.size(), typed ? typed_r : model_r);
    requests_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic add_row(input op_t o, input logic [VALUE_W-1:0] v,
                         input logic [POS_W-1:0] p, input int rpt, input logic typed,
                         input status_t st, input logic [VALUE_W-1:0] data,
                         input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.op = o;
    row.value = v;
    row.pos = p;
    row.rpt = rpt[4:0];
    row.typed = typed;
    row.st = st;
    row.data = data;
    row.cnt = cnt;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        oldest_result = pending_results.pop_front();
        results_seen++;
        if (status !== oldest_result.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, oldest_result.st));
        if (read_data !== oldest_result.data)
          report_mismatch($sformatf("read_data %h, expected %h", read_data,
                                    oldest_result.data));
        if (count !== oldest_result.cnt)
          report_mismatch($sformatf("count %0d, expected %0d", count, oldest_result.cnt));
      end
    end
  end

  initial begin
    stim_row_t          row;
    result_t            typed_r;
    int                 idle_pct;
    int                 append_pct;
    int                 sel;
    op_t                rand_op;
    logic [VALUE_W-1:0] rand_val;
    logic [POS_W-1:0]   rand_pos;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // empty list, then a single entry removed again
    add_row(OP_READ,   32'h0,          4'd0,  1, 1'b1, ST_RANGE,     32'h0,          5'd0);
    add_row(OP_SEARCH, 32'h0,          4'd0,  1, 1'b1, ST_NOT_FOUND, 32'h0,          5'd0);
    add_row(OP_REMOVE, 32'h0,          4'd0,  1, 1'b1, ST_NOT_FOUND, 32'h0,          5'd0);
    add_row(OP_APPEND, 32'h0,          4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd1);
    add_row(OP_REMOVE, 32'h0,          4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd0);
    add_row(OP_READ,   32'h0,          4'd0,  1, 1'b1, ST_RANGE,     32'h0,          5'd0);
    // duplicates and extremes, remove the first of two equal entries
    add_row(OP_APPEND, 32'hFFFF_FFFF,  4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd1);
    add_row(OP_APPEND, 32'h0,          4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd2);
    add_row(OP_APPEND, 32'h1234_5678,  4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd3);
    add_row(OP_APPEND, 32'h0,          4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd4);
    add_row(OP_READ,   32'h0,          4'd0,  1, 1'b1, ST_OK,        32'hFFFF_FFFF,  5'd4);
    add_row(OP_READ,   32'h0,          4'd15, 1, 1'b1, ST_RANGE,     32'h0,          5'd4);
    add_row(OP_SEARCH, 32'h1234_5678,  4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd4);
    add_row(OP_REMOVE, 32'h0,          4'd0,  1, 1'b1, ST_OK,        32'h0,          5'd3);
    add_row(OP_READ,   32'h0,          4'd1,  1, 1'b0, ST_OK,        32'h0,          5'd0);
    add_row(OP_READ,   32'h0,          4'd3,  1, 1'b1, ST_RANGE,     32'h0,          5'd3);
    add_row(OP_READ,   32'h0,          4'd2,  1, 1'b0, ST_OK,        32'h0,          5'd0);
    // fill to capacity, then refuse one more
    add_row(OP_APPEND, 32'hA5A5_0000,  4'd0,  13, 1'b0, ST_OK,       32'h0,          5'd0);
    add_row(OP_APPEND, 32'h5A5A_5A5A,  4'd0,  1, 1'b1, ST_FULL,      32'h0,          5'd16);
    add_row(OP_READ,   32'h0,          4'd15, 1, 1'b0, ST_OK,        32'h0,          5'd0);
    add_row(OP_SEARCH, 32'h5A5A_5A5A,  4'd0,  1, 1'b1, ST_NOT_FOUND, 32'h0,          5'd16);
    add_row(OP_REMOVE, 32'hFFFF_FFFF,  4'd0,  1, 1'b0, ST_OK,        32'h0,          5'd0);
    add_row(OP_REMOVE, 32'hA5A5_000C,  4'd0,  1, 1'b0, ST_OK,        32'h0,          5'd0);
    add_row(OP_READ,   32'h0,          4'd0,  1, 1'b0, ST_OK,        32'h0,          5'd0);
    add_row(OP_SEARCH, 32'h0,          4'd0,  1, 1'b0, ST_OK,        32'h0,          5'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      typed_r.st = row.st;
      typed_r.data = row.data;
      typed_r.cnt = row.cnt;
      for (int k = 0; k < row.rpt; k++) begin
        send_request(row.op, row.value + k, row.pos, row.typed, typed_r, 30);
      end
    end

    // phases: back to back, heavy request gaps, light gaps, back to back again
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 2) ? 25 : 0;
      append_pct = 45;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // swing between filling and draining so both ends get reached
        if (n % 20 == 0) append_pct = $urandom_range(20, 70);
        sel = $urandom_range(0, 99);
        if (sel < append_pct) rand_op = OP_APPEND;
        else if (sel < append_pct + (100 - append_pct) / 3) rand_op = OP_REMOVE;
        else if (sel < append_pct + 2 * (100 - append_pct) / 3) rand_op = OP_SEARCH;
        else rand_op = OP_READ;

        sel = $urandom_range(0, 3);
        if (list_len > 0 && sel < 2 && rand_op != OP_APPEND)
          rand_val = list_entries[$urandom_range(0, list_len - 1)];
        else if (sel != 3)
          rand_val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          rand_val = $urandom;

        if (list_len > 0 && $urandom_range(0, 3) != 0)
          rand_pos = POS_W'($urandom_range(0, list_len - 1));
        else
          rand_pos = POS_W'($urandom_range(0, 15));

        send_request(rand_op, rand_val, rand_pos, 1'b0, '0, idle_pct);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d requests and checked %0d results; list full %0d times,",
             requests_sent, results_seen, full_refusals);
    $display("emptied by remove %0d times, search hits %0d", list_emptied, search_hits);
    if (mismatches == 0) begin
      $display("ordered_value_list test passed");
    end else begin
      $display("ordered_value_list test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("ordered_value_list test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ovl_pkg.sv
rtl/ovl_ctrl.sv
rtl/ovl_dp.sv
rtl/ordered_value_list.sv
rtl/ovl_chk.sv
tb/sv/ordered_value_list_tb.sv
